@@ sv/flash_block_page_state_tracker_assert.svh @@
// assertion macros for the flash block page state tracker
// concurrent checks on a named clock and active-low reset, empty in synthesis
`ifndef FLASH_BLOCK_PAGE_STATE_TRACKER_ASSERT_SVH
`define FLASH_BLOCK_PAGE_STATE_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define FBPT_ASSERT_CR(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FBPT_ASSERT(lbl, prop, msg) `FBPT_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)
`else
`define FBPT_ASSERT_CR(lbl, clk, rst_n, prop, msg)
`define FBPT_ASSERT(lbl, prop, msg)
`endif
`endif

@@ sv/fbpt_pkg.sv @@
// shared codes and types for the flash block page state tracker
// no dependencies
`timescale 1ns / 1ps

package fbpt_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_INVAL = 2'd1;
  localparam logic [1:0] CMD_ERASE = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  localparam logic [1:0] PG_EMPTY   = 2'd0;
  localparam logic [1:0] PG_VALID   = 2'd1;
  localparam logic [1:0] PG_INVALID = 2'd2;

  localparam logic [1:0] BLK_FREE     = 2'd0;
  localparam logic [1:0] BLK_ACTIVE   = 2'd1;
  localparam logic [1:0] BLK_INACTIVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_ERASES = 2'd1;
  localparam logic [1:0] ST_NOT_EMPTY = 2'd2;

  localparam logic REG_ERASE_LIMIT = 1'b0;
  localparam logic REG_PAGES       = 1'b1;

  localparam logic [19:0] ERASE_LIMIT_RST = 20'd100000;
  localparam logic [6:0]  PAGES_RST       = 7'd64;

  typedef struct packed {
    logic        wr_limit;
    logic [19:0] wdata;
    logic [19:0] erase_limit;
    logic [6:0]  pages;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  page_code;
    logic [6:0]  valid_pages;
    logic [6:0]  invalid_pages;
    logic [6:0]  empty_pages;
    logic [1:0]  blk_mode;
    logic [5:0]  next_empty_page;
    logic        has_empty;
    logic [19:0] erase_count;
  } result_t;

endpackage

@@ sv/fbpt_page_mem.sv @@
// page state memory, one port, registered read data
// depends on nothing beyond its parameters
`timescale 1ns / 1ps

module fbpt_page_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [1:0]    wdata_i,
  output logic [1:0]    rdata_o
);

  logic [1:0] mem_q [DEPTH];
  logic [1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/fbpt_seq.sv @@
// command sequencer: page read, update, clear sweep and empty-page scan
// uses fbpt_pkg, fbpt_page_mem and the assertion macro header
`timescale 1ns / 1ps
`include "flash_block_page_state_tracker_assert.svh"

module fbpt_seq import fbpt_pkg::*; #(
  parameter int MAX_PAGES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] cmd_i,
  input  logic [5:0] page_index_i,
  input  logic       is_noop_i,
  input  cfg_t       cfg_i,
  input  logic       res_ready_i,
  output logic       busy_o,
  output logic       res_valid_o,
  output result_t    res_o
);

  localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int SW = (CW > 7) ? CW : 7;
  localparam int UW = SW + 1;
  localparam int XW = (AW > 6) ? AW : 6;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;
  localparam logic [2:0] S_SCAN = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] chk_q, chk_d;
  logic          chk_vld_q, chk_vld_d;
  logic [1:0]    cmd_q, cmd_d;
  logic [5:0]    page_q, page_d;
  logic          noop_q, noop_d;
  logic          in_use_q, in_use_d;
  logic [CW-1:0] valid_q, valid_d;
  logic [CW-1:0] invalid_q, invalid_d;
  logic [1:0]    mode_q, mode_d;
  logic [19:0]   erases_q, erases_d;
  logic [1:0]    status_q, status_d;
  logic [1:0]    pso_q, pso_d;
  logic [5:0]    next_q, next_d;
  logic          has_q, has_d;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [1:0]    mem_wdata, mem_rdata;
  logic          erase_go;

  logic [SW-1:0] pages_x, size_x;
  logic [XW-1:0] page_x;
  logic [AW-1:0] page_addr;
  logic          cnt_last, cnt_in_size;
  logic [UW-1:0] used_x, empty_x, inv_sum;

  assign pages_x = SW'(cfg_i.pages);
  assign size_x  = (pages_x == '0) ? SW'(1) :
                   (pages_x > SW'(MAX_PAGES)) ? SW'(MAX_PAGES) : pages_x;
  assign page_x    = XW'(page_q);
  assign page_addr = page_x[AW-1:0];
  assign cnt_last    = (cnt_q == CW'(MAX_PAGES - 1));
  assign cnt_in_size = (SW'(cnt_q) < size_x);
  assign inv_sum = UW'(invalid_q) + UW'(1);
  assign used_x  = UW'(valid_q) + UW'(invalid_q);
  assign empty_x = (used_x >= UW'(size_x)) ? '0 : UW'(size_x) - used_x;

  fbpt_page_mem #(
    .DEPTH(MAX_PAGES),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    chk_d     = chk_q;
    chk_vld_d = 1'b0;
    cmd_d     = cmd_q;
    page_d    = page_q;
    noop_d    = noop_q;
    in_use_d  = in_use_q;
    valid_d   = valid_q;
    invalid_d = invalid_q;
    mode_d    = mode_q;
    erases_d  = erases_q;
    status_d  = status_q;
    pso_d     = pso_q;
    next_d    = next_q;
    has_d     = has_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = cnt_q[AW-1:0];
    mem_wdata = PG_EMPTY;
    erase_go  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_INIT: begin
        mem_we = 1'b1;
        if (cnt_last) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_d    = cmd_i;
          page_d   = page_index_i;
          noop_d   = is_noop_i;
          in_use_d = (SW'(page_index_i) < size_x);
          state_d  = S_RD;
        end
      end
      S_RD: begin
        if (in_use_q) begin
          mem_re   = 1'b1;
          mem_addr = page_addr;
        end
        state_d = S_EXEC;
      end
      S_EXEC: begin
        status_d = ST_OK;
        pso_d    = in_use_q ? mem_rdata : PG_EMPTY;
        case (cmd_q)
          CMD_WRITE: begin
            if (in_use_q) begin
              if (mem_rdata != PG_EMPTY) begin
                status_d = ST_NOT_EMPTY;
              end else if (!noop_q) begin
                mem_we    = 1'b1;
                mem_addr  = page_addr;
                mem_wdata = PG_VALID;
                valid_d   = valid_q + CW'(1);
                mode_d    = BLK_ACTIVE;
                pso_d     = PG_VALID;
              end
            end
          end
          CMD_INVAL: begin
            if (in_use_q && (mem_rdata != PG_INVALID)) begin
              if ((mem_rdata == PG_VALID) && (valid_q != '0)) begin
                valid_d = valid_q - CW'(1);
              end
              invalid_d = inv_sum[CW-1:0];
              mem_we    = 1'b1;
              mem_addr  = page_addr;
              mem_wdata = PG_INVALID;
              pso_d     = PG_INVALID;
              mode_d    = (inv_sum >= UW'(size_x)) ? BLK_INACTIVE : BLK_ACTIVE;
            end
          end
          CMD_ERASE: begin
            if (!noop_q) begin
              if (erases_q == '0) begin
                status_d = ST_NO_ERASES;
              end else begin
                erase_go  = 1'b1;
                erases_d  = erases_q - 20'd1;
                valid_d   = '0;
                invalid_d = '0;
                mode_d    = BLK_FREE;
                pso_d     = PG_EMPTY;
              end
            end
          end
          default: begin
          end
        endcase
        cnt_d   = '0;
        state_d = erase_go ? S_CLR : S_SCAN;
      end
      S_CLR: begin
        mem_we = 1'b1;
        if (cnt_last) begin
          cnt_d   = '0;
          next_d  = '0;
          has_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_SCAN: begin
        if (chk_vld_q && (mem_rdata == PG_EMPTY)) begin
          next_d  = 6'(chk_q);
          has_d   = 1'b1;
          state_d = S_DONE;
        end else if (!chk_vld_q && !cnt_in_size) begin
          next_d  = '0;
          has_d   = 1'b0;
          state_d = S_DONE;
        end else if (cnt_in_size) begin
          mem_re    = 1'b1;
          chk_d     = cnt_q;
          chk_vld_d = 1'b1;
          cnt_d     = cnt_q + CW'(1);
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_i.wr_limit) begin
      erases_d = cfg_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      cnt_q     <= '0;
      chk_vld_q <= 1'b0;
      valid_q   <= '0;
      invalid_q <= '0;
      mode_q    <= BLK_FREE;
      erases_q  <= ERASE_LIMIT_RST;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      chk_vld_q <= chk_vld_d;
      valid_q   <= valid_d;
      invalid_q <= invalid_d;
      mode_q    <= mode_d;
      erases_q  <= erases_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_q    <= chk_d;
    cmd_q    <= cmd_d;
    page_q   <= page_d;
    noop_q   <= noop_d;
    in_use_q <= in_use_d;
    status_q <= status_d;
    pso_q    <= pso_d;
    next_q   <= next_d;
    has_q    <= has_d;
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    res_o.status          = status_q;
    res_o.page_code       = pso_q;
    res_o.valid_pages     = 7'(valid_q);
    res_o.invalid_pages   = 7'(invalid_q);
    res_o.empty_pages     = empty_x[6:0];
    res_o.blk_mode        = mode_q;
    res_o.next_empty_page = next_q;
    res_o.has_empty       = has_q;
    res_o.erase_count     = cfg_i.erase_limit - erases_q;
  end

  `FBPT_ASSERT(a_cnt_bound, (CW+1)'(valid_q) + (CW+1)'(invalid_q) <= (CW+1)'(MAX_PAGES), "page counts exceed block size")
  `FBPT_ASSERT(a_scan_no_write, (state_q == S_SCAN) |-> !mem_we, "page write during scan")
  `FBPT_ASSERT(a_erase_clear, (state_q == S_EXEC) && erase_go |=> (state_q == S_CLR) && (valid_q == '0) && (invalid_q == '0), "erase did not clear counts")

endmodule

@@ sv/flash_block_page_state_tracker.sv @@
// write, invalidate, query and a noop or refused erase end with an empty-page scan that
// reads one page per cycle from the single-port page memory;
// a successful erase instead runs a clearing pass over all MAX_PAGES pages
// one transaction at a time: the next is taken once the result is registered
// reset: clears counts and mode, loads erase limit 100000 and 64 pages, then runs a
// clearing pass over every page of the page memory while input is stalled
`timescale 1ns / 1ps
`include "flash_block_page_state_tracker_assert.svh"

module flash_block_page_state_tracker import fbpt_pkg::*; #(
  parameter int MAX_PAGES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [19:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [5:0]  page_index_i,
  input  logic        is_noop_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [1:0]  page_state_out_o,
  output logic [6:0]  valid_pages_o,
  output logic [6:0]  invalid_pages_o,
  output logic [6:0]  empty_pages_o,
  output logic [1:0]  block_state_out_o,
  output logic [5:0]  next_empty_page_o,
  output logic        has_empty_o,
  output logic [19:0] erase_count_o
);

  logic [19:0] erase_limit_q;
  logic [6:0]  pages_q;
  cfg_t        cfg;
  logic        busy, res_valid, res_ready, load;
  result_t     res;
  result_t     out_q;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      erase_limit_q <= ERASE_LIMIT_RST;
      pages_q       <= PAGES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ERASE_LIMIT: erase_limit_q <= cfg_wdata_i;
        REG_PAGES:       pages_q       <= cfg_wdata_i[6:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.wr_limit    = cfg_we_i && (cfg_idx_i == REG_ERASE_LIMIT);
  assign cfg.wdata       = cfg_wdata_i;
  assign cfg.erase_limit = erase_limit_q;
  assign cfg.pages       = pages_q;

  fbpt_seq #(
    .MAX_PAGES(MAX_PAGES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && !busy),
    .cmd_i       (cmd_i),
    .page_index_i(page_index_i),
    .is_noop_i   (is_noop_i),
    .cfg_i       (cfg),
    .res_ready_i (res_ready),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign in_stall_o = busy;

  // output register
  assign res_ready = !out_valid_q || !out_stall_i;
  assign load      = res_valid && res_ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign page_state_out_o  = out_q.page_code;
  assign valid_pages_o     = out_q.valid_pages;
  assign invalid_pages_o   = out_q.invalid_pages;
  assign empty_pages_o     = out_q.empty_pages;
  assign block_state_out_o = out_q.blk_mode;
  assign next_empty_page_o = out_q.next_empty_page;
  assign has_empty_o       = out_q.has_empty;
  assign erase_count_o     = out_q.erase_count;

  `FBPT_ASSERT(a_accept_busy, in_valid_i && !in_stall_o |=> in_stall_o, "accepted transaction did not make block busy")

endmodule
